@@ rtl/bfbm_pkg.sv @@
// Shared constants, types and codes for the best-fit block matcher.
// No dependencies; every other file but bfbm_ram imports this package.
package bfbm_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W     = 31;
    localparam int SLOT_W     = 6;
    localparam int MODE_W     = 2;

    localparam logic [SIZE_W-1:0] FIT_CEILING = SIZE_W'(32'h4000_0000);

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_REQ   = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic step;
    } t_cmp_ctl;

endpackage

@@ rtl/bfbm_ram.sv @@
// Single-port-write, single-port-read RAM with registered read data.
// Generic; no package dependency.
module bfbm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bfbm_cmp_unit.sv @@
// Shared best-fit compare unit: one stored size per step against the running best.
// Depends on bfbm_pkg.
module bfbm_cmp_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bfbm_pkg::t_cmp_ctl          i_ctl,
    input  logic [bfbm_pkg::SIZE_W-1:0] i_req,
    input  logic [bfbm_pkg::SIZE_W-1:0] i_size,
    input  logic [bfbm_pkg::IDX_W-1:0]  i_idx,
    input  logic                        i_used,
    output logic                        o_have,
    output logic [bfbm_pkg::IDX_W-1:0]  o_best_idx
);
    import bfbm_pkg::*;

    logic              r_have;
    logic [SIZE_W-1:0] r_best;
    logic [IDX_W-1:0]  r_best_idx;
    logic              hit;

    assign hit = i_ctl.step && !i_used && (i_size >= i_req) && (i_size < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.start) begin
            r_have <= 1'b0;
        end else if (hit) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_best     <= FIT_CEILING;
            r_best_idx <= '0;
        end else if (hit) begin
            r_best     <= i_size;
            r_best_idx <= i_idx;
        end
    end

    assign o_have     = r_have;
    assign o_best_idx = r_best_idx;

endmodule

@@ rtl/best_fit_block_matcher.sv @@
// Best-fit block matcher top level: sequencer, used marks, count and result register.
// Depends on bfbm_pkg, bfbm_ram and bfbm_cmp_unit.
//
// Each input beat gives exactly one result beat. A clear or a load goes straight to the
// done state, which puts its result in the output register; the next beat is taken
// after that. A request walks the stored blocks: one compare unit reads the size memory
// one entry per cycle through its single registered read port, a final scan step drains
// the last compare, then the mark state marks the chosen block and the done state loads
// the result register. The input is not ready while an item is in progress; a finished
// result waits in the output register without holding up acceptance of the next beat,
// but the next item holds in its last cycle until that waiting result is taken.
module best_fit_block_matcher (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bfbm_pkg::MODE_W-1:0] i_mode,
    input  logic [bfbm_pkg::SIZE_W-1:0] i_size,
    input  logic                        i_first,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_found,
    output logic [bfbm_pkg::SLOT_W-1:0] o_slot,
    output logic                        o_all_fit,
    output logic                        o_dropped
);
    import bfbm_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    logic [MAX_BLOCKS-1:0] r_used;
    logic              r_failed;
    logic [CNT_W-1:0]  r_rd_idx;
    logic [SIZE_W-1:0] r_req;
    logic              r_pipe_vld;
    logic [IDX_W-1:0]  r_pipe_idx;
    logic              r_pipe_used;
    logic              r_res_found;
    logic [SLOT_W-1:0] r_res_slot;
    logic              r_res_dropped;
    logic              r_o_valid;
    logic              r_o_found;
    logic [SLOT_W-1:0] r_o_slot;
    logic              r_o_all_fit;
    logic              r_o_dropped;

    logic              in_acc;
    logic              issue;
    logic              out_free;
    logic              has_room;
    logic              ram_we;
    logic [SIZE_W-1:0] ram_rdata;
    t_cmp_ctl          cmp_ctl;
    logic              cmp_have;
    logic [IDX_W-1:0]  cmp_best_idx;

    assign o_ready  = (r_state == ST_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign issue    = (r_state == ST_SCAN) && (r_rd_idx < r_count);
    assign out_free = !r_o_valid || i_ready;
    assign has_room = (r_count < CNT_W'(MAX_BLOCKS));
    assign ram_we   = in_acc && (i_mode == MODE_LOAD) && has_room;

    assign cmp_ctl.start = in_acc;
    assign cmp_ctl.step  = r_pipe_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_mode == MODE_REQ) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (!issue) begin
                    n_state = ST_MARK;
                end
            end
            ST_MARK: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_used     <= '0;
            r_failed   <= 1'b0;
            r_pipe_vld <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_pipe_vld <= issue;
            if (in_acc) begin
                case (i_mode)
                    MODE_CLEAR: begin
                        r_count <= '0;
                        r_used  <= '0;
                    end
                    MODE_LOAD: begin
                        if (has_room) begin
                            r_count <= r_count + 1'b1;
                            r_used[r_count[IDX_W-1:0]] <= 1'b0;
                        end
                    end
                    MODE_REQ: begin
                        if (i_first) begin
                            r_used   <= '0;
                            r_failed <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_MARK) begin
                if (cmp_have) begin
                    r_used[cmp_best_idx] <= 1'b1;
                end else begin
                    r_failed <= 1'b1;
                end
            end
            if (r_state == ST_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req         <= i_size;
            r_rd_idx      <= '0;
            r_res_found   <= 1'b0;
            r_res_slot    <= '0;
            r_res_dropped <= (i_mode == MODE_LOAD) && !has_room;
        end
        if (issue) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        r_pipe_idx  <= r_rd_idx[IDX_W-1:0];
        r_pipe_used <= r_used[r_rd_idx[IDX_W-1:0]];
        if (r_state == ST_MARK) begin
            r_res_found <= cmp_have;
            r_res_slot  <= cmp_have ? SLOT_W'(cmp_best_idx) : '0;
        end
        if (r_state == ST_DONE && out_free) begin
            r_o_found   <= r_res_found;
            r_o_slot    <= r_res_slot;
            r_o_all_fit <= !r_failed;
            r_o_dropped <= r_res_dropped;
        end
    end

    bfbm_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (SIZE_W)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_size),
        .i_re    (issue),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    bfbm_cmp_unit u_cmp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (cmp_ctl),
        .i_req      (r_req),
        .i_size     (ram_rdata),
        .i_idx      (r_pipe_idx),
        .i_used     (r_pipe_used),
        .o_have     (cmp_have),
        .o_best_idx (cmp_best_idx)
    );

    assign o_valid   = r_o_valid;
    assign o_found   = r_o_found;
    assign o_slot    = r_o_slot;
    assign o_all_fit = r_o_all_fit;
    assign o_dropped = r_o_dropped;

    a_mark_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MARK) |-> !r_pipe_vld)
        else $error("mark reached with a compare still in flight");

    a_chosen_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MARK && cmp_have) |-> !r_used[cmp_best_idx])
        else $error("best-fit choice already marked used");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("block count beyond table depth");

    a_fail_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MARK && !cmp_have) |=> r_failed)
        else $error("failed request did not set failure flag");

endmodule

@@ test/best_fit_checker.sv @@
// Best-fit block matcher checker: watches both channels, predicts every result beat
// from its own copy of the size table and compares field by field in order.
// Depends on bfbm_pkg for widths, the fit ceiling and the mode codes.
module best_fit_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [bfbm_pkg::MODE_W-1:0] i_mode,
    input  logic [bfbm_pkg::SIZE_W-1:0] i_size,
    input  logic                        i_first,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_found,
    input  logic [bfbm_pkg::SLOT_W-1:0] i_slot,
    input  logic                        i_all_fit,
    input  logic                        i_dropped,
    output int                          o_mismatches,
    output int                          o_pending,
    output int                          o_beats,
    output int                          o_results,
    output int                          o_fits,
    output int                          o_misses,
    output int                          o_drops
);
    import bfbm_pkg::*;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic              all_fit;
        logic              dropped;
    } t_fit_result;

    logic [SIZE_W-1:0] size_tbl [MAX_BLOCKS];
    logic              used_tbl [MAX_BLOCKS];
    int unsigned       stored;
    logic              match_lost;

    t_fit_result fit_q [$];
    t_fit_result want;
    t_fit_result got;
    int          mismatches;
    int          beats;
    int          results;
    int          fits;
    int          misses;
    int          drops;

    function automatic t_fit_result match_beat(t_mode m, logic [SIZE_W-1:0] sz, logic f);
        t_fit_result       r;
        logic [SIZE_W-1:0] best;
        int                best_idx;
        logic              have;
        r        = '0;
        best     = FIT_CEILING;
        best_idx = 0;
        have     = 1'b0;
        case (m)
            MODE_CLEAR: begin
                stored = 0;
                foreach (used_tbl[i]) used_tbl[i] = 1'b0;
            end
            MODE_LOAD: begin
                if (stored < MAX_BLOCKS) begin
                    size_tbl[stored] = sz;
                    used_tbl[stored] = 1'b0;
                    stored++;
                end else begin
                    r.dropped = 1'b1;
                end
            end
            MODE_REQ: begin
                if (f) begin
                    foreach (used_tbl[i]) used_tbl[i] = 1'b0;
                    match_lost = 1'b0;
                end
                for (int i = 0; i < stored; i++) begin
                    if (!used_tbl[i] && size_tbl[i] >= sz && size_tbl[i] < best) begin
                        best     = size_tbl[i];
                        best_idx = i;
                        have     = 1'b1;
                    end
                end
                if (have) begin
                    used_tbl[best_idx] = 1'b1;
                    r.found = 1'b1;
                    r.slot  = SLOT_W'(best_idx);
                end else begin
                    match_lost = 1'b1;
                end
            end
            default: ;
        endcase
        r.all_fit = !match_lost;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored     = 0;
            match_lost = 1'b0;
            foreach (used_tbl[i]) used_tbl[i] = 1'b0;
            fit_q.delete();
            mismatches = 0;
            beats      = 0;
            results    = 0;
            fits       = 0;
            misses     = 0;
            drops      = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_found, i_slot, i_all_fit, i_dropped};
                if (fit_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: result beat with none expected, got %p", got);
                end else begin
                    want = fit_q.pop_front();
                    results++;
                    if (got.found !== want.found || got.slot !== want.slot ||
                        got.all_fit !== want.all_fit || got.dropped !== want.dropped) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at result %0d: found %b/%b slot %0d/%0d %s%b/%b %s%b/%b",
                                     results, want.found, got.found, want.slot, got.slot,
                                     "all_fit ", want.all_fit, got.all_fit,
                                     "dropped ", want.dropped, got.dropped);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = match_beat(t_mode'(i_mode), i_size, i_first);
                fit_q.push_back(want);
                beats++;
                if (want.found) fits++;
                if (want.dropped) drops++;
                if (t_mode'(i_mode) == MODE_REQ && !want.found) misses++;
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= fit_q.size();
        o_beats      <= beats;
        o_results    <= results;
        o_fits       <= fits;
        o_misses     <= misses;
        o_drops      <= drops;
    end

endmodule

@@ test/testbench.sv @@
// Testbench top for the best-fit block matcher: clock, reset, stimulus and verdict.
// Depends on bfbm_pkg, best_fit_block_matcher and best_fit_checker.
module testbench;
    import bfbm_pkg::*;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [MODE_W-1:0] i_mode  = '0;
    logic [SIZE_W-1:0] i_size  = '0;
    logic              i_first = 1'b0;
    logic              i_ready = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic              o_found;
    logic [SLOT_W-1:0] o_slot;
    logic              o_all_fit;
    logic              o_dropped;

    int mismatches;
    int pending;
    int beats;
    int results;
    int fits;
    int misses;
    int drops;

    int idle_pct  = 0;
    int stall_pct = 0;
    int sent      = 0;
    int phase_end;

    best_fit_block_matcher u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_mode    (i_mode),
        .i_size    (i_size),
        .i_first   (i_first),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_found   (o_found),
        .o_slot    (o_slot),
        .o_all_fit (o_all_fit),
        .o_dropped (o_dropped)
    );

    best_fit_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_mode       (i_mode),
        .i_size       (i_size),
        .i_first      (i_first),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_found      (o_found),
        .i_slot       (o_slot),
        .i_all_fit    (o_all_fit),
        .i_dropped    (o_dropped),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_beats      (beats),
        .o_results    (results),
        .o_fits       (fits),
        .o_misses     (misses),
        .o_drops      (drops)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_beat(t_mode m, logic [SIZE_W-1:0] s, logic f);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid <= 1'b1;
        i_mode  <= m;
        i_size  <= s;
        i_first <= f;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [SIZE_W-1:0] rand_size();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55) return SIZE_W'($urandom_range(0, 40));
        if (pick < 70) return SIZE_W'($urandom);
        if (pick < 80) return FIT_CEILING + SIZE_W'($urandom_range(0, 8)) - SIZE_W'(4);
        if (pick < 88) return SIZE_W'($urandom_range(0, 2000));
        if (pick < 94) return '1;
        return '0;
    endfunction

    task automatic run_sequence();
        int n_loads;
        int n_matches;
        int n_reqs;
        if ($urandom_range(9) == 0)
            send_beat(t_mode'($urandom_range(3)), rand_size(), 1'($urandom_range(1)));
        if ($urandom_range(5) != 0)
            send_beat(MODE_CLEAR, rand_size(), 1'($urandom_range(1)));
        n_loads = ($urandom_range(11) == 0) ? $urandom_range(58, 70) : $urandom_range(0, 10);
        repeat (n_loads) send_beat(MODE_LOAD, rand_size(), 1'($urandom_range(1)));
        n_matches = $urandom_range(1, 3);
        repeat (n_matches) begin
            n_reqs = $urandom_range(1, 12);
            send_beat(MODE_REQ, rand_size(), ($urandom_range(7) != 0));
            repeat (n_reqs - 1) send_beat(MODE_REQ, rand_size(), ($urandom_range(15) == 0));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_beat(MODE_REQ,   '0, 1'b1);
        send_beat(MODE_NONE,  '1, 1'b1);
        send_beat(MODE_CLEAR, '0, 1'b1);
        send_beat(MODE_LOAD,  '1, 1'b1);
        send_beat(MODE_LOAD,  FIT_CEILING, 1'b0);
        send_beat(MODE_LOAD,  FIT_CEILING - SIZE_W'(1), 1'b0);
        send_beat(MODE_LOAD,  '0, 1'b0);
        send_beat(MODE_LOAD,  SIZE_W'(5), 1'b0);
        send_beat(MODE_LOAD,  SIZE_W'(5), 1'b1);
        send_beat(MODE_LOAD,  SIZE_W'(9), 1'b0);
        send_beat(MODE_REQ,   SIZE_W'(5), 1'b1);
        send_beat(MODE_REQ,   SIZE_W'(5), 1'b0);
        send_beat(MODE_REQ,   '0, 1'b0);
        send_beat(MODE_REQ,   FIT_CEILING, 1'b0);
        send_beat(MODE_REQ,   '0, 1'b0);
        send_beat(MODE_REQ,   '0, 1'b0);
        send_beat(MODE_REQ,   '0, 1'b0);
        send_beat(MODE_REQ,   FIT_CEILING - SIZE_W'(1), 1'b1);
        send_beat(MODE_REQ,   '1, 1'b0);
        send_beat(MODE_NONE,  '0, 1'b0);
        send_beat(MODE_CLEAR, '1, 1'b0);
        send_beat(MODE_REQ,   '0, 1'b1);
        send_beat(MODE_LOAD,  SIZE_W'(1), 1'b0);
        send_beat(MODE_REQ,   SIZE_W'(1), 1'b1);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 67; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 67; end
                default: begin idle_pct = 17; stall_pct <= 17; end
            endcase
            if (p == 2) drain();
            phase_end = sent + 380;
            while (sent < phase_end) run_sequence();
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (80) @(posedge i_clk);

        $display("Covered %0d input beats and %0d result beats over four handshake phases.",
                 beats, results);
        $display("Requests fitted %0d, missed %0d; loads dropped on a full table %0d.",
                 fits, misses, drops);
        if (mismatches == 0) begin
            $display("PASS best_fit_block_matcher");
        end else begin
            $display("FAIL best_fit_block_matcher");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("FAIL best_fit_block_matcher");
        $finish;
    end

endmodule
